// ===== rtl/core/minv3_pkg.sv =====
// shared types and constants for the 3x3 fixed-point matrix inverse
// no dependencies; imported by every module of the block

package minv3_pkg;

    localparam int ELEM_WIDTH    = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int N_ELEM        = 9;

    // exact widths of the intermediate integers
    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int COF_W  = 2 * ELEM_WIDTH + 1;
    localparam int PART_W = 2 * ELEM_WIDTH + 1;
    localparam int DET_W  = 3 * ELEM_WIDTH + 3;
    localparam int REM_W  = DET_W + 1;

    // pipeline depth of the shared front end and of one divider lane
    localparam int FRONT_STAGES = 6;
    localparam int LANE_STAGES  = ELEM_WIDTH + 2;

    typedef logic [ELEM_WIDTH-1:0] elem_t;
    typedef elem_t [N_ELEM-1:0]    mat_t;
    typedef logic [3:0]            idx_t;

    // saturation limits on the rounded quotient magnitude and the clamped results
    localparam logic [ELEM_WIDTH:0] LIM_POS = {2'b00, {(ELEM_WIDTH-1){1'b1}}};
    localparam logic [ELEM_WIDTH:0] LIM_NEG = {2'b01, {(ELEM_WIDTH-1){1'b0}}};
    localparam elem_t SAT_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam elem_t SAT_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

    // cofactor k = m[a]*m[b] - m[c]*m[d], already transposed into the adjugate
    localparam idx_t COF_IDX [N_ELEM][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    typedef struct packed {
        logic signed [ELEM_WIDTH-1:0] e00;
        logic signed [ELEM_WIDTH-1:0] e01;
        logic signed [ELEM_WIDTH-1:0] e02;
        logic signed [ELEM_WIDTH-1:0] e10;
        logic signed [ELEM_WIDTH-1:0] e11;
        logic signed [ELEM_WIDTH-1:0] e12;
        logic signed [ELEM_WIDTH-1:0] e20;
        logic signed [ELEM_WIDTH-1:0] e21;
        logic signed [ELEM_WIDTH-1:0] e22;
    } minv3_in_t;

    typedef struct packed {
        logic                         invertible;
        logic signed [ELEM_WIDTH-1:0] r00;
        logic signed [ELEM_WIDTH-1:0] r01;
        logic signed [ELEM_WIDTH-1:0] r02;
        logic signed [ELEM_WIDTH-1:0] r10;
        logic signed [ELEM_WIDTH-1:0] r11;
        logic signed [ELEM_WIDTH-1:0] r12;
        logic signed [ELEM_WIDTH-1:0] r20;
        logic signed [ELEM_WIDTH-1:0] r21;
        logic signed [ELEM_WIDTH-1:0] r22;
    } minv3_out_t;

endpackage

// ===== rtl/core/minv3_front.sv =====
// front end: cofactors, determinant and the signed magnitudes fed to the divider lanes
// depends on minv3_pkg

module minv3_front
    import minv3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int NUM_W = COF_W + 2 * FRAC_BITS
) (
    input  logic                           aclk,
    input  logic [FRONT_STAGES-1:0]        en,
    input  mat_t                           mat,
    output logic                           det_zero,
    output logic                           det_neg,
    output logic [DET_W-1:0]               det_mag,
    output logic [N_ELEM-1:0]              num_neg,
    output logic [N_ELEM-1:0][NUM_W-1:0]   num_mag
);

    localparam int EXT_W = DET_W - PART_W - ELEM_WIDTH;

    mat_t                      m_reg;
    logic signed [PROD_W-1:0]  prod_reg [2*N_ELEM];
    elem_t [2:0]               col1_reg;
    elem_t [2:0]               col2_reg;
    logic signed [COF_W-1:0]   cof2_reg [N_ELEM];
    logic signed [COF_W-1:0]   cof3_reg [N_ELEM];
    logic signed [COF_W-1:0]   cof4_reg [N_ELEM];
    logic signed [PART_W-1:0]  lo_reg [3];
    logic signed [PART_W-1:0]  hi_reg [3];
    logic signed [DET_W-1:0]   det4_reg;
    logic signed [DET_W-1:0]   det_next;
    logic signed [DET_W-1:0]   term [3];
    logic [COF_W-1:0]          cof_abs [N_ELEM];

    // capture the request
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            m_reg <= mat;
        end
    end

    // two products per cofactor, first column kept for the determinant
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int k = 0; k < N_ELEM; k++) begin
                prod_reg[2*k]   <= $signed(m_reg[COF_IDX[k][0]]) * $signed(m_reg[COF_IDX[k][1]]);
                prod_reg[2*k+1] <= $signed(m_reg[COF_IDX[k][2]]) * $signed(m_reg[COF_IDX[k][3]]);
            end
            col1_reg[0] <= m_reg[0];
            col1_reg[1] <= m_reg[3];
            col1_reg[2] <= m_reg[6];
        end
    end

    // exact cofactors
    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int k = 0; k < N_ELEM; k++) begin
                cof2_reg[k] <= COF_W'(prod_reg[2*k]) - COF_W'(prod_reg[2*k+1]);
            end
            col2_reg <= col1_reg;
        end
    end

    // determinant partial products, cofactor split into low and high halves
    always_ff @(posedge aclk) begin
        if (en[3]) begin
            for (int j = 0; j < 3; j++) begin
                lo_reg[j] <= $signed(col2_reg[j])
                           * $signed({1'b0, cof2_reg[j][ELEM_WIDTH-1:0]});
                hi_reg[j] <= $signed(col2_reg[j])
                           * $signed(cof2_reg[j][COF_W-1:ELEM_WIDTH]);
            end
            cof3_reg <= cof2_reg;
        end
    end

    // recombine partials and sum the three terms
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            term[j] = $signed({{EXT_W{hi_reg[j][PART_W-1]}}, hi_reg[j], {ELEM_WIDTH{1'b0}}})
                    + DET_W'(lo_reg[j]);
        end
        det_next = term[0] + term[1] + term[2];
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            det4_reg <= det_next;
            cof4_reg <= cof3_reg;
        end
    end

    // signs and magnitudes for the dividers
    always_comb begin
        for (int k = 0; k < N_ELEM; k++) begin
            cof_abs[k] = cof4_reg[k][COF_W-1] ? COF_W'(-cof4_reg[k]) : COF_W'(cof4_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            det_zero <= (det4_reg == '0);
            det_neg  <= det4_reg[DET_W-1];
            det_mag  <= det4_reg[DET_W-1] ? DET_W'(-det4_reg) : DET_W'(det4_reg);
            for (int k = 0; k < N_ELEM; k++) begin
                num_neg[k] <= cof4_reg[k][COF_W-1];
                num_mag[k] <= {cof_abs[k], {(2*FRAC_BITS){1'b0}}};
            end
        end
    end

endmodule

// ===== rtl/core/minv3_div_lane.sv =====
// one divider lane: restoring division one quotient bit per stage, round and saturate
// depends on minv3_pkg

module minv3_div_lane
    import minv3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int NUM_W = COF_W + 2 * FRAC_BITS
) (
    input  logic                           aclk,
    input  logic [LANE_STAGES-1:0]         en,
    input  logic [DET_W-1:0]               d_in,
    input  logic [ELEM_WIDTH:0][DET_W-1:0] d_pipe,
    input  logic                           det_neg,
    input  logic                           num_neg,
    input  logic [NUM_W-1:0]               num_mag,
    output elem_t                          res
);

    logic [REM_W-1:0]      rem_reg  [ELEM_WIDTH+1];
    elem_t                 q_reg    [ELEM_WIDTH+1];
    elem_t                 low_reg  [ELEM_WIDTH+1];
    logic [ELEM_WIDTH:0]   ovf_reg;
    logic [ELEM_WIDTH:0]   neg_reg;
    elem_t                 res_reg;

    logic [REM_W-1:0]      trial    [ELEM_WIDTH+1];
    logic [REM_W-1:0]      rem_next [ELEM_WIDTH+1];
    logic [ELEM_WIDTH:0]   qbit;
    logic [REM_W-1:0]      top_ext;
    logic                  round_up;
    logic [ELEM_WIDTH:0]   q_up;
    logic [ELEM_WIDTH:0]   q_neg;
    logic                  sat;
    elem_t                 res_next;

    // high part of the numerator starts the remainder; quotient overflow if it reaches d
    assign top_ext = REM_W'(num_mag[NUM_W-1:ELEM_WIDTH]);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            rem_reg[0] <= top_ext;
            ovf_reg[0] <= (top_ext >= {1'b0, d_in});
            low_reg[0] <= num_mag[ELEM_WIDTH-1:0];
            q_reg[0]   <= '0;
            neg_reg[0] <= num_neg ^ det_neg;
        end
    end

    // trial subtract for every stage
    always_comb begin
        trial[0]    = '0;
        rem_next[0] = '0;
        qbit[0]     = 1'b0;
        for (int s = 1; s <= ELEM_WIDTH; s++) begin
            trial[s]    = {rem_reg[s-1][REM_W-2:0], low_reg[s-1][ELEM_WIDTH-1]};
            qbit[s]     = (trial[s] >= {1'b0, d_pipe[s-1]});
            rem_next[s] = qbit[s] ? trial[s] - {1'b0, d_pipe[s-1]} : trial[s];
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 1; s <= ELEM_WIDTH; s++) begin
            if (en[s]) begin
                rem_reg[s] <= rem_next[s];
                q_reg[s]   <= {q_reg[s-1][ELEM_WIDTH-2:0], qbit[s]};
                low_reg[s] <= {low_reg[s-1][ELEM_WIDTH-2:0], 1'b0};
                ovf_reg[s] <= ovf_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
            end
        end
    end

    // round half away from zero, apply sign, clamp
    always_comb begin
        round_up = ({rem_reg[ELEM_WIDTH][REM_W-2:0], 1'b0} >= {1'b0, d_pipe[ELEM_WIDTH]});
        q_up     = {1'b0, q_reg[ELEM_WIDTH]} + {{ELEM_WIDTH{1'b0}}, round_up};
        q_neg    = -q_up;
        if (neg_reg[ELEM_WIDTH]) begin
            sat = ovf_reg[ELEM_WIDTH] || (q_up > LIM_NEG);
        end else begin
            sat = ovf_reg[ELEM_WIDTH] || (q_up > LIM_POS);
        end
        if (sat) begin
            res_next = neg_reg[ELEM_WIDTH] ? SAT_MIN : SAT_MAX;
        end else begin
            res_next = neg_reg[ELEM_WIDTH] ? q_neg[ELEM_WIDTH-1:0] : q_up[ELEM_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[LANE_STAGES-1]) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== rtl/core/matrix_inverse_3x3.sv =====
// 3x3 Q-format matrix inverse by the adjugate, top level
// depends on minv3_pkg, minv3_front, minv3_div_lane
//
// Usage: one request on s_ (valid/ready) carries a whole 3x3 matrix, row-major.
// One result leaves on m_ (valid/ready): invertible flag plus nine inverse
// elements, rounded to nearest (ties away from zero) and saturated. A singular
// matrix gives invertible = 0 and all elements zero.
// Pipeline: six front stages (products, cofactors, determinant, magnitudes),
// nine divider lanes of ELEM_WIDTH + 2 stages each, one quotient bit per
// stage, and the output register; the first stage loads at the accepting edge.
// Throughput: one matrix per cycle while the output is not stalled; the nine lanes run in lockstep.
// Stall: every stage holds when the one after it is full and stalled; empty
// stages still fill, so s_ready stays high until the whole pipeline is full.
// Reset: aresetn (synchronous, active low) empties the pipeline; no requests
// are lost after reset since none are held.

module matrix_inverse_3x3
    import minv3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  minv3_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output minv3_out_t m_data
);

    localparam int NUM_W = COF_W + 2 * FRAC_BITS;
    localparam int NS    = FRONT_STAGES + LANE_STAGES + 1;

    logic [NS-1:0]                   v_reg;
    logic [NS-1:0]                   v_next;
    logic [NS-1:0]                   en;
    mat_t                            mat;
    logic                            det_zero;
    logic                            det_neg;
    logic [DET_W-1:0]                det_mag;
    logic [N_ELEM-1:0]               num_neg;
    logic [N_ELEM-1:0][NUM_W-1:0]    num_mag;
    logic [ELEM_WIDTH:0][DET_W-1:0]  d_pipe_reg;
    logic [LANE_STAGES-1:0]          zero_pipe_reg;
    logic [LANE_STAGES-1:0]          lane_en;
    elem_t [N_ELEM-1:0]              lane_res;
    minv3_out_t                      out_reg;

    // stage enables: a stage moves when it is empty or the next one moves
    always_comb begin
        en[NS-1] = !v_reg[NS-1] || m_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_comb begin
        v_next = v_reg;
        if (en[0]) begin
            v_next[0] = s_valid;
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                v_next[k] = v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = en[0];
    assign lane_en = en[FRONT_STAGES + LANE_STAGES - 1:FRONT_STAGES];

    // unpack the request into an element array
    always_comb begin
        mat[0] = s_data.e00;
        mat[1] = s_data.e01;
        mat[2] = s_data.e02;
        mat[3] = s_data.e10;
        mat[4] = s_data.e11;
        mat[5] = s_data.e12;
        mat[6] = s_data.e20;
        mat[7] = s_data.e21;
        mat[8] = s_data.e22;
    end

    minv3_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk     (aclk),
        .en       (en[FRONT_STAGES-1:0]),
        .mat      (mat),
        .det_zero (det_zero),
        .det_neg  (det_neg),
        .det_mag  (det_mag),
        .num_neg  (num_neg),
        .num_mag  (num_mag)
    );

    // divisor and singular flag travel once, shared by all lanes
    always_ff @(posedge aclk) begin
        if (lane_en[0]) begin
            d_pipe_reg[0]    <= det_mag;
            zero_pipe_reg[0] <= det_zero;
        end
        for (int s = 1; s <= ELEM_WIDTH; s++) begin
            if (lane_en[s]) begin
                d_pipe_reg[s] <= d_pipe_reg[s-1];
            end
        end
        for (int s = 1; s < LANE_STAGES; s++) begin
            if (lane_en[s]) begin
                zero_pipe_reg[s] <= zero_pipe_reg[s-1];
            end
        end
    end

    // nine divider lanes in lockstep
    for (genvar g = 0; g < N_ELEM; g++) begin : g_lane
        minv3_div_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .aclk    (aclk),
            .en      (lane_en),
            .d_in    (det_mag),
            .d_pipe  (d_pipe_reg),
            .det_neg (det_neg),
            .num_neg (num_neg[g]),
            .num_mag (num_mag[g]),
            .res     (lane_res[g])
        );
    end

    // merge lanes into the result, forcing zeros for a singular matrix
    always_ff @(posedge aclk) begin
        if (en[NS-1]) begin
            out_reg.invertible <= !zero_pipe_reg[LANE_STAGES-1];
            out_reg.r00 <= zero_pipe_reg[LANE_STAGES-1] ? '0 : lane_res[0];
            out_reg.r01 <= zero_pipe_reg[LANE_STAGES-1] ? '0 : lane_res[1];
            out_reg.r02 <= zero_pipe_reg[LANE_STAGES-1] ? '0 : lane_res[2];
            out_reg.r10 <= zero_pipe_reg[LANE_STAGES-1] ? '0 : lane_res[3];
            out_reg.r11 <= zero_pipe_reg[LANE_STAGES-1] ? '0 : lane_res[4];
            out_reg.r12 <= zero_pipe_reg[LANE_STAGES-1] ? '0 : lane_res[5];
            out_reg.r20 <= zero_pipe_reg[LANE_STAGES-1] ? '0 : lane_res[6];
            out_reg.r21 <= zero_pipe_reg[LANE_STAGES-1] ? '0 : lane_res[7];
            out_reg.r22 <= zero_pipe_reg[LANE_STAGES-1] ? '0 : lane_res[8];
        end
    end

    assign m_valid = v_reg[NS-1];
    assign m_data  = out_reg;

endmodule

// ===== rtl/core/minv3_checker.sv =====
// port-level checks for the matrix inverse, bound to the top level
// depends on minv3_pkg and matrix_inverse_3x3

module minv3_checker
    import minv3_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input minv3_out_t m_data
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // reset empties the output
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a draining output lets the whole pipeline move
    assert property (@(posedge aclk) disable iff (!aresetn) m_ready |-> s_ready)
        else $error("input blocked while output drains");

    // an empty output stage means nothing is stalled upstream
    assert property (@(posedge aclk) disable iff (!aresetn) !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    // singular results carry zero elements
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.invertible |->
            m_data.r00 == '0 && m_data.r01 == '0 && m_data.r02 == '0 &&
            m_data.r10 == '0 && m_data.r11 == '0 && m_data.r12 == '0 &&
            m_data.r20 == '0 && m_data.r21 == '0 && m_data.r22 == '0)
        else $error("singular result with nonzero elements");

endmodule

bind matrix_inverse_3x3 minv3_checker u_minv3_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== test/testbench.sv =====
// testbench for matrix_inverse_3x3: directed and random 3x3 Q16.16 matrices
// depends on minv3_pkg and the matrix_inverse_3x3 rtl; exact wide-integer predictor inside

module testbench
    import minv3_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC       = 16;
    localparam int WIDE       = 200;
    localparam int N_RANDOM   = 1650;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 80;

    typedef logic signed [WIDE-1:0] wide_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    minv3_in_t  s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    minv3_out_t m_data;

    minv3_out_t expected_inverses[$];
    int         mismatch_count = 0;
    int         cycle_count = 0;

    matrix_inverse_3x3 #(.FRAC_BITS(FRAC)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Verification failed");
            $finish;
        end
    end

    // exact inverse: adjugate over determinant, round half away, saturate
    function automatic minv3_out_t predict_inverse(minv3_in_t a);
        logic [9*ELEM_WIDTH-1:0] flat;
        logic [9*ELEM_WIDTH:0]   packed_res;
        wide_t m[9];
        wide_t c[9];
        wide_t det, dmag, num, nmag, q, r;
        logic  dneg, nneg;
        flat = a;
        for (int k = 0; k < 9; k++)
            m[k] = wide_t'($signed(flat[(8-k)*ELEM_WIDTH +: ELEM_WIDTH]));
        for (int k = 0; k < 9; k++)
            c[k] = m[COF_IDX[k][0]] * m[COF_IDX[k][1]] - m[COF_IDX[k][2]] * m[COF_IDX[k][3]];
        det = m[0] * c[0] + m[3] * c[1] + m[6] * c[2];
        if (det == 0)
            return '0;
        dneg = det < 0;
        dmag = dneg ? -det : det;
        packed_res = '0;
        packed_res[9*ELEM_WIDTH] = 1'b1;
        for (int k = 0; k < 9; k++) begin
            num  = c[k] <<< (2 * FRAC);
            nneg = num < 0;
            nmag = nneg ? -num : num;
            q = wide_t'($unsigned(nmag) / $unsigned(dmag));
            r = wide_t'($unsigned(nmag) % $unsigned(dmag));
            if ((r <<< 1) >= dmag)
                q = q + 1;
            if (nneg != dneg)
                q = -q;
            if (q > wide_t'(SAT_MAX))
                q = wide_t'(SAT_MAX);
            else if (q < wide_t'($signed(SAT_MIN)))
                q = wide_t'($signed(SAT_MIN));
            packed_res[(8-k)*ELEM_WIDTH +: ELEM_WIDTH] = q[ELEM_WIDTH-1:0];
        end
        return packed_res;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %h want %h at cycle %0d", field, got, want, cycle_count);
        mismatch_count++;
    endtask

    // result checker
    always @(posedge aclk) begin
        minv3_out_t want;
        logic [9*ELEM_WIDTH:0] g, w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_inverses.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = expected_inverses.pop_front();
                g = m_data;
                w = want;
                if (g[9*ELEM_WIDTH] !== w[9*ELEM_WIDTH])
                    report_mismatch("invertible", g[9*ELEM_WIDTH], w[9*ELEM_WIDTH]);
                for (int k = 0; k < 9; k++)
                    if (g[(8-k)*ELEM_WIDTH +: ELEM_WIDTH] !== w[(8-k)*ELEM_WIDTH +: ELEM_WIDTH])
                        report_mismatch($sformatf("r%0d%0d", k / 3, k % 3),
                                        g[(8-k)*ELEM_WIDTH +: ELEM_WIDTH],
                                        w[(8-k)*ELEM_WIDTH +: ELEM_WIDTH]);
            end
        end
    end

    // receiver stall pattern: steady ready, light random stalls, heavy random stalls
    always @(posedge aclk) begin
        int phase;
        phase = (cycle_count / 300) % 3;
        if (phase == 0)
            m_ready <= 1'b1;
        else if (phase == 1)
            m_ready <= ($urandom_range(0, 3) != 0);
        else
            m_ready <= ($urandom_range(0, 1) != 0);
    end

    // send one request and queue its expected inverse
    task automatic send_matrix(minv3_in_t mat);
        s_valid <= 1'b1;
        s_data  <= mat;
        do @(posedge aclk); while (!s_ready);
        expected_inverses.push_back(predict_inverse(mat));
    endtask

    task automatic idle_cycles(int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    function automatic minv3_in_t make_matrix(logic [31:0] e[9]);
        logic [9*ELEM_WIDTH-1:0] flat;
        for (int k = 0; k < 9; k++)
            flat[(8-k)*ELEM_WIDTH +: ELEM_WIDTH] = e[k];
        return flat;
    endfunction

    function automatic logic [31:0] random_elem(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            2: return $signed($urandom_range(0, 255)) - 128;
            default: return (($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff);
        endcase
    endfunction

    // extremes, identity, singular and saturating cases
    task automatic test_directed();
        logic [31:0] e[9];
        e = '{32'h1_0000, 0, 0, 0, 32'h1_0000, 0, 0, 0, 32'h1_0000};
        send_matrix(make_matrix(e));
        e = '{default: 0};
        send_matrix(make_matrix(e));
        e = '{default: 32'h7fff_ffff};
        send_matrix(make_matrix(e));
        e = '{default: 32'h8000_0000};
        send_matrix(make_matrix(e));
        // tiny diagonal saturates high, negated saturates low
        e = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_matrix(make_matrix(e));
        e = '{32'hffff_ffff, 0, 0, 0, 32'hffff_ffff, 0, 0, 0, 32'hffff_ffff};
        send_matrix(make_matrix(e));
        // huge diagonal goes to near zero
        e = '{32'h7fff_ffff, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h7fff_ffff};
        send_matrix(make_matrix(e));
        e = '{32'h8000_0000, 32'h7fff_ffff, 0, 0, 32'h8000_0000, 32'h7fff_ffff,
              32'h7fff_ffff, 0, 32'h8000_0000};
        send_matrix(make_matrix(e));
        // rank deficient: repeated row, zero column
        e = '{32'h2_0000, 32'h3_0000, 32'h1_8000, 32'h2_0000, 32'h3_0000, 32'h1_8000,
              32'h5, 32'h7, 32'h9};
        send_matrix(make_matrix(e));
        e = '{0, 32'h1_0000, 2, 0, 32'h3_0000, 4, 0, 5, 6};
        send_matrix(make_matrix(e));
        // ties: det 2 scaled, odd numerators
        e = '{2, 0, 0, 0, 32'h2_0000, 0, 0, 0, 32'h3_0000};
        send_matrix(make_matrix(e));
        e = '{32'h3_0000, 32'h1_0000, 0, 32'h1_0000, 32'hfffd_0000, 0, 0, 0,
              32'h7_0000};
        send_matrix(make_matrix(e));
        // permutation and general small matrix
        e = '{0, 32'h1_0000, 0, 0, 0, 32'hffff_0000, 32'h1_0000, 0, 0};
        send_matrix(make_matrix(e));
        e = '{32'h1_8000, 32'hffff_4000, 32'h0_2000, 32'h0_1000, 32'h2_0000,
              32'hfffe_8000, 32'h0_0001, 32'h0_7fff, 32'h1_0001};
        send_matrix(make_matrix(e));
        idle_cycles(1);
    endtask

    // random matrices in bursts with gaps
    task automatic test_random();
        logic [31:0] e[9];
        int sent, burst, mode;
        sent = 0;
        while (sent < N_RANDOM) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && sent < N_RANDOM; b++) begin
                mode = $urandom_range(0, 9);
                for (int k = 0; k < 9; k++)
                    e[k] = random_elem(mode < 3 ? 0 : mode < 7 ? 1 : mode < 9 ? 2 : 3);
                // some singular ones: copy a row or scale a row
                if ($urandom_range(0, 9) == 0)
                    for (int k = 0; k < 3; k++) e[6 + k] = e[k];
                else if ($urandom_range(0, 14) == 0)
                    for (int k = 0; k < 3; k++) e[3 + k] = e[k] * 2;
                // occasional diagonal matrix: off-diagonal elements zeroed
                if (mode == 1 && $urandom_range(0, 1) != 0)
                    for (int k = 0; k < 9; k++) if (k % 4 != 0) e[k] = 0;
                send_matrix(make_matrix(e));
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 12));
        end
        idle_cycles(1);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        // drain the pipeline
        while (expected_inverses.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0 && expected_inverses.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
